[hdl/ssfb_pkg.sv]
package ssfb_pkg;

  localparam int MAX_CHARS  = 16;
  localparam int NUM_DIGITS = 4;

  // frame: data cmd, addr cmd, digits, display-on cmd
  localparam int FRAME_LEN = NUM_DIGITS + 3;
  localparam int CNT_W     = $clog2(MAX_CHARS + 1);
  localparam int IDX_W     = $clog2(FRAME_LEN);
  localparam int DIG_W     = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
  localparam int BRIGHT_W  = 3;

  localparam logic [7:0] CMD_DATA  = 8'h40;
  localparam logic [7:0] CMD_ADDR  = 8'hC0;
  localparam logic [7:0] CMD_ON    = 8'h88;
  localparam logic [7:0] SEG_POINT = 8'h80;
  localparam logic [7:0] SEG_DASH  = 8'h40;
  localparam logic [7:0] SEG_BLANK = 8'h00;

  localparam logic [BRIGHT_W-1:0] BRIGHT_RST = 3'd7;

  localparam logic [7:0] CH_DOT  = 8'h2E;
  localparam logic [7:0] CH_DASH = 8'h2D;
  localparam logic [7:0] CH_0    = 8'h30;
  localparam logic [7:0] CH_9    = 8'h39;
  localparam logic [7:0] CH_UA   = 8'h41;
  localparam logic [7:0] CH_UF   = 8'h46;
  localparam logic [7:0] CH_LA   = 8'h61;
  localparam logic [7:0] CH_LF   = 8'h66;

  localparam logic [7:0] GLYPH_ROM [16] = '{
    8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07,
    8'h7F, 8'h6F, 8'h77, 8'h7C, 8'h39, 8'h5E, 8'h79, 8'h71
  };

  typedef struct packed {
    logic [7:0] character;
    logic       end_of_string;
  } in_t;

  typedef struct packed {
    logic [7:0] bus_byte;
    logic       start_before;
    logic       stop_after;
    logic       last_of_run;
  } out_t;

  // one captured frame; seg[0] is the leftmost digit
  typedef struct packed {
    logic [NUM_DIGITS-1:0][7:0] seg;
    logic [BRIGHT_W-1:0]        bright;
  } frame_t;

  function automatic logic [7:0] encode_glyph(input logic [7:0] ch);
    logic [7:0] ofs;
    logic [7:0] seg;
    ofs = 8'h00;
    seg = SEG_BLANK;
    if (ch >= CH_0 && ch <= CH_9) begin
      ofs = ch - CH_0;
      seg = GLYPH_ROM[ofs[3:0]];
    end else if (ch >= CH_UA && ch <= CH_UF) begin
      ofs = ch - CH_UA + 8'd10;
      seg = GLYPH_ROM[ofs[3:0]];
    end else if (ch >= CH_LA && ch <= CH_LF) begin
      ofs = ch - CH_LA + 8'd10;
      seg = GLYPH_ROM[ofs[3:0]];
    end else if (ch == CH_DASH) begin
      seg = SEG_DASH;
    end
    return seg;
  endfunction

endpackage

[hdl/ssfb_window.sv]
module ssfb_window (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        accept,
  input  ssfb_pkg::in_t               in_data,
  input  logic [ssfb_pkg::BRIGHT_W-1:0] bright,
  output logic                        frame_ld,
  output ssfb_pkg::frame_t            frame
);
  import ssfb_pkg::*;

  logic [NUM_DIGITS-1:0][7:0] win_r, win_nxt, win_upd;
  logic [CNT_W-1:0]           cnt_r, cnt_nxt, cnt_upd;

  always_comb begin
    win_upd = win_r;
    cnt_upd = cnt_r;
    if (cnt_r < CNT_W'(MAX_CHARS)) begin
      if (in_data.character == CH_DOT) begin
        // leading dot has no digit to attach to
        if (cnt_r != '0) begin
          win_upd[NUM_DIGITS-1] = win_r[NUM_DIGITS-1] | SEG_POINT;
        end
      end else begin
        for (int i = 0; i < NUM_DIGITS - 1; i++) begin
          win_upd[i] = win_r[i+1];
        end
        win_upd[NUM_DIGITS-1] = encode_glyph(in_data.character);
        cnt_upd = cnt_r + CNT_W'(1);
      end
    end
  end

  always_comb begin
    win_nxt = win_r;
    cnt_nxt = cnt_r;
    if (accept) begin
      if (in_data.end_of_string) begin
        win_nxt = '0;
        cnt_nxt = '0;
      end else begin
        win_nxt = win_upd;
        cnt_nxt = cnt_upd;
      end
    end
  end

  assign frame_ld     = accept && in_data.end_of_string;
  assign frame.seg    = win_upd;
  assign frame.bright = bright;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
      cnt_r <= '0;
    end else begin
      win_r <= win_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

[hdl/ssfb_emitter.sv]
module ssfb_emitter (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              frame_ld,
  input  ssfb_pkg::frame_t  frame,
  output logic              busy,
  output logic              out_valid,
  input  logic              out_ready,
  output ssfb_pkg::out_t    out_data
);
  import ssfb_pkg::*;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_LEN - 1);
  localparam logic [IDX_W-1:0] SEG_LAST = IDX_W'(FRAME_LEN - 2);

  logic              frm_vld_r, frm_vld_nxt;
  frame_t            frm_r, frm_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [IDX_W-1:0]  seg_idx;
  logic              out_vld_r, out_vld_nxt;
  out_t              out_r, out_nxt;
  out_t              beat;
  logic              load_out;

  assign load_out = frm_vld_r && (!out_vld_r || out_ready);
  assign seg_idx  = idx_r - IDX_W'(2);

  always_comb begin
    beat = '0;
    if (idx_r == '0) begin
      beat.bus_byte     = CMD_DATA;
      beat.start_before = 1'b1;
      beat.stop_after   = 1'b1;
    end else if (idx_r == IDX_W'(1)) begin
      beat.bus_byte     = CMD_ADDR;
      beat.start_before = 1'b1;
    end else if (idx_r == LAST_IDX) begin
      beat.bus_byte     = CMD_ON | {5'b0, frm_r.bright};
      beat.start_before = 1'b1;
      beat.stop_after   = 1'b1;
      beat.last_of_run  = 1'b1;
    end else begin
      beat.bus_byte   = frm_r.seg[seg_idx[DIG_W-1:0]];
      beat.stop_after = (idx_r == SEG_LAST);
    end
  end

  always_comb begin
    frm_vld_nxt = frm_vld_r;
    frm_nxt     = frm_r;
    idx_nxt     = idx_r;
    out_vld_nxt = out_vld_r;
    out_nxt     = out_r;
    if (out_ready) begin
      out_vld_nxt = 1'b0;
    end
    if (load_out) begin
      out_vld_nxt = 1'b1;
      out_nxt     = beat;
      if (idx_r == LAST_IDX) begin
        idx_nxt     = '0;
        frm_vld_nxt = 1'b0;
      end else begin
        idx_nxt = idx_r + IDX_W'(1);
      end
    end
    // loads only arrive while the frame slot is empty
    if (frame_ld) begin
      frm_vld_nxt = 1'b1;
      frm_nxt     = frame;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frm_vld_r <= 1'b0;
      idx_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      frm_vld_r <= frm_vld_nxt;
      idx_r     <= idx_nxt;
      out_vld_r <= out_vld_nxt;
    end
    frm_r <= frm_nxt;
    out_r <= out_nxt;
  end

  assign busy      = frm_vld_r;
  assign out_valid = out_vld_r;
  assign out_data  = out_r;

endmodule

[hdl/seven_segment_string_frame_builder_core.sv]
// Seven-segment string formatter. Characters of a display string arrive one
// per input beat (in_data.character, with in_data.end_of_string on the final
// one) and are taken one per clock. Hex digits 0-9, A-F, a-f become glyphs,
// '-' the middle bar, any other byte a blank digit; a '.' lights the point of
// the previous digit (leading dots dropped). The last four digits are kept
// right-aligned, blank-padded on the left, and after 16 kept characters the
// rest of the string is ignored. The end-of-string beat is folded in first,
// then a seven-beat command frame goes out: 0x40 (start+stop), 0xC0 (start),
// four segment bytes leftmost first (stop after the fourth), and 0x88 |
// brightness (start+stop, last_of_run). Output beats come from a register,
// one per clock while out_ready is high. The frame is held in a one-deep
// frame buffer: plain characters keep flowing while it drains, but a second
// end-of-string beat waits (in_ready low) until the previous frame's last
// beat has entered the output register. The first result beat of a frame
// passes through the frame slot, then the output register. Brightness
// (cfg_wr_data, reset 7) is written with cfg_wr_en and sampled when the
// frame is captured.
module seven_segment_string_frame_builder_core (
  input  logic                          clk,
  input  logic                          rst_n,
  // character input
  input  logic                          in_valid,
  output logic                          in_ready,
  input  ssfb_pkg::in_t                 in_data,
  // bus byte output
  output logic                          out_valid,
  input  logic                          out_ready,
  output ssfb_pkg::out_t                out_data,
  // brightness register
  input  logic                          cfg_wr_en,
  input  logic [ssfb_pkg::BRIGHT_W-1:0] cfg_wr_data
);
  import ssfb_pkg::*;

  logic [BRIGHT_W-1:0] bright_r, bright_nxt;
  logic                accept;
  logic                frame_ld;
  logic                frame_busy;
  frame_t              frame;

  // only a frame-ending beat needs the frame slot
  assign in_ready = !(frame_busy && in_data.end_of_string);
  assign accept   = in_valid && in_ready;

  assign bright_nxt = cfg_wr_en ? cfg_wr_data : bright_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bright_r <= BRIGHT_RST;
    end else begin
      bright_r <= bright_nxt;
    end
  end

  // digit window: encode + shift per character, snapshot on end of string
  ssfb_window u_window (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .in_data  (in_data),
    .bright   (bright_r),
    .frame_ld (frame_ld),
    .frame    (frame)
  );

  // frame buffer + beat sequencer + output register
  ssfb_emitter u_emitter (
    .clk       (clk),
    .rst_n     (rst_n),
    .frame_ld  (frame_ld),
    .frame     (frame),
    .busy      (frame_busy),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

[hdl/ssfb_checker.sv]
module ssfb_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_ready,
  input ssfb_pkg::out_t                out_data
);
  import ssfb_pkg::*;

  logic out_beat;
  assign out_beat = out_valid && out_ready;

  // no beat is offered right after reset
  a_rst_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled output beat changed");

  // closing beat is always the display-on command
  a_last_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    out_beat && out_data.last_of_run |->
      out_data.start_before && out_data.stop_after &&
      out_data.bus_byte[7:3] == CMD_ON[7:3])
    else $error("last beat is not display-on");

  // start without stop only on the address command
  a_addr_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    out_beat && out_data.start_before && !out_data.stop_after |->
      out_data.bus_byte == CMD_ADDR && !out_data.last_of_run)
    else $error("bad open-ended command beat");

  // the address command is followed by a segment beat
  a_addr_then_seg: assert property (@(posedge clk) disable iff (!rst_n)
    out_beat && out_data.start_before && !out_data.stop_after |=>
      !out_valid || !out_data.start_before)
    else $error("address command not followed by segment byte");

endmodule

bind seven_segment_string_frame_builder_core ssfb_checker u_ssfb_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .out_data    (out_data)
);

[test/seven_segment_string_frame_builder_core_tb.sv]
`timescale 1ns / 100ps

// Checks the seven-segment frame builder. A scoreboard folds every accepted
// character into its own copy of the digit window and queues the seven bus
// beats each end-of-string should produce. Output beats are compared in order.
module seven_segment_string_frame_builder_core_tb;
  import ssfb_pkg::*;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_t in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;
  logic cfg_wr_en;
  logic [BRIGHT_W-1:0] cfg_wr_data;

  // scoreboard state
  logic [7:0] shown [NUM_DIGITS];
  int kept;
  logic [BRIGHT_W-1:0] bright_now;
  out_t pending_beats [$];
  int errs;

  // idle chance in percent per beat, each side
  int tx_pct;
  int rx_pct;

  seven_segment_string_frame_builder_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always #5 clk = ~clk;

  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

  function automatic logic [7:0] hex_seg(input logic [3:0] nib);
    logic [7:0] s;
    case (nib)
      4'h0: s = 8'h3F;
      4'h1: s = 8'h06;
      4'h2: s = 8'h5B;
      4'h3: s = 8'h4F;
      4'h4: s = 8'h66;
      4'h5: s = 8'h6D;
      4'h6: s = 8'h7D;
      4'h7: s = 8'h07;
      4'h8: s = 8'h7F;
      4'h9: s = 8'h6F;
      4'hA: s = 8'h77;
      4'hB: s = 8'h7C;
      4'hC: s = 8'h39;
      4'hD: s = 8'h5E;
      4'hE: s = 8'h79;
      default: s = 8'h71;
    endcase
    return s;
  endfunction

  function automatic logic [7:0] seg_for(input logic [7:0] c);
    logic [7:0] d;
    if (c >= CH_0 && c <= CH_9) begin
      d = c - CH_0;
      return hex_seg(d[3:0]);
    end
    if (c >= CH_UA && c <= CH_UF) begin
      d = c - CH_UA + 8'd10;
      return hex_seg(d[3:0]);
    end
    if (c >= CH_LA && c <= CH_LF) begin
      d = c - CH_LA + 8'd10;
      return hex_seg(d[3:0]);
    end
    if (c == CH_DASH) return SEG_DASH;
    return SEG_BLANK;
  endfunction

  function automatic void push_beat(input logic [7:0] b, input logic st,
                                    input logic sp, input logic lst);
    out_t x;
    x.bus_byte     = b;
    x.start_before = st;
    x.stop_after   = sp;
    x.last_of_run  = lst;
    pending_beats.push_back(x);
  endfunction

  // take one character into the window; end of string queues the frame
  function automatic void fold_char(input in_t it);
    if (kept < MAX_CHARS) begin
      if (it.character == CH_DOT) begin
        if (kept > 0) shown[NUM_DIGITS-1] = shown[NUM_DIGITS-1] | SEG_POINT;
      end else begin
        for (int i = 0; i < NUM_DIGITS - 1; i++) shown[i] = shown[i+1];
        shown[NUM_DIGITS-1] = seg_for(it.character);
        kept++;
      end
    end
    if (it.end_of_string) begin
      push_beat(CMD_DATA, 1'b1, 1'b1, 1'b0);
      push_beat(CMD_ADDR, 1'b1, 1'b0, 1'b0);
      for (int i = 0; i < NUM_DIGITS; i++)
        push_beat(shown[i], 1'b0, i == NUM_DIGITS - 1, 1'b0);
      push_beat(CMD_ON | {5'd0, bright_now}, 1'b1, 1'b1, 1'b1);
      for (int i = 0; i < NUM_DIGITS; i++) shown[i] = SEG_BLANK;
      kept = 0;
    end
  endfunction

  function automatic void note_error(input string msg);
    errs++;
    if (errs <= 10) $display("ERROR @%0t: %s", $realtime, msg);
  endfunction

  // output check first, then fold the accepted input beat
  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_beats.size() == 0) begin
        note_error($sformatf("unexpected beat byte=%02h st=%b sp=%b last=%b",
          out_data.bus_byte, out_data.start_before, out_data.stop_after,
          out_data.last_of_run));
      end else begin
        want = pending_beats.pop_front();
        if (out_data.bus_byte !== want.bus_byte ||
            out_data.start_before !== want.start_before ||
            out_data.stop_after !== want.stop_after ||
            out_data.last_of_run !== want.last_of_run) begin
          note_error($sformatf(
            "beat mismatch exp byte=%02h st=%b sp=%b last=%b got byte=%02h st=%b sp=%b last=%b",
            want.bus_byte, want.start_before, want.stop_after, want.last_of_run,
            out_data.bus_byte, out_data.start_before, out_data.stop_after,
            out_data.last_of_run));
        end
      end
    end
    if (rst_n && in_valid && in_ready) fold_char(in_data);
  end

  // receiver: drops out_ready in random stall bursts
  initial begin
    int hold;
    hold = 0;
    out_ready = 1'b1;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        hold--;
        out_ready <= 1'b0;
      end else if (rx_pct > 0 && $urandom_range(0, 99) < rx_pct) begin
        hold = $urandom_range(0, 12);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // one input beat; valid stays high afterwards unless the caller drops it
  task automatic send_char(input logic [7:0] ch, input logic eos);
    int gap;
    gap = 0;
    if (tx_pct > 0 && $urandom_range(0, 99) < tx_pct) gap = $urandom_range(1, 13);
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= '{character: ch, end_of_string: eos};
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk);
    // allow the last beat and any in-flight character to settle
    repeat (8) @(posedge clk);
  endtask

  task automatic set_brightness(input logic [BRIGHT_W-1:0] v);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    bright_now = v;
  endtask

  function automatic logic [7:0] random_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 20) return CH_0 + 8'($urandom_range(0, 9));
    if (r < 30) return CH_UA + 8'($urandom_range(0, 5));
    if (r < 40) return CH_LA + 8'($urandom_range(0, 5));
    if (r < 50) return CH_DASH;
    if (r < 65) return CH_DOT;
    return 8'($urandom_range(0, 255));
  endfunction

  // leading dot dropped, point on a digit, dash, zero byte as the last char
  task automatic test_dots_and_dash();
    send_char(CH_DOT, 1'b0);
    send_char(CH_0 + 8'd8, 1'b0);
    send_char(CH_DOT, 1'b0);
    send_char(CH_DASH, 1'b0);
    send_char(8'h00, 1'b1);
    wait_idle();
  endtask

  // only dots: blank segment bytes, brightness at its low extreme
  task automatic test_dots_only();
    set_brightness(3'd0);
    send_char(CH_DOT, 1'b0);
    send_char(CH_DOT, 1'b1);
    wait_idle();
  endtask

  // sixteen kept characters, then a dot and a digit that must be ignored
  task automatic test_char_limit();
    logic [7:0] txt [16];
    txt = '{CH_0, CH_9, CH_UA, CH_UF, CH_LA, CH_LF, 8'hFF, 8'h47,
            CH_DASH, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37};
    set_brightness(3'd5);
    foreach (txt[i]) send_char(txt[i], 1'b0);
    send_char(CH_DOT, 1'b0);
    send_char(CH_UA + 8'd4, 1'b1);
    wait_idle();
  endtask

  task automatic test_random_strings(input int n_items, input int tx_p, input int rx_p);
    int sent;
    int len;
    tx_pct = tx_p;
    rx_pct = rx_p;
    sent = 0;
    while (sent < n_items) begin
      // mostly short strings, now and then one past the character limit
      if ($urandom_range(0, 7) == 0) len = $urandom_range(MAX_CHARS + 1, MAX_CHARS + 6);
      else len = $urandom_range(1, 6);
      for (int i = 0; i < len; i++) send_char(random_char(), i == len - 1);
      sent += len;
    end
    wait_idle();
  endtask

  initial begin
    errs        = 0;
    kept        = 0;
    bright_now  = BRIGHT_RST;
    for (int i = 0; i < NUM_DIGITS; i++) shown[i] = SEG_BLANK;
    tx_pct      = 25;
    rx_pct      = 25;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    test_dots_and_dash();
    test_dots_only();
    test_char_limit();

    set_brightness(3'($urandom_range(0, 7)));
    test_random_strings(40, 30, 30);
    set_brightness(3'd7);
    test_random_strings(30, 0, 50);
    set_brightness(3'($urandom_range(0, 7)));
    test_random_strings(30, 0, 0);

    if (errs == 0 && pending_beats.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
